>>> hw/rtl/utu_pkg.sv
// ----------------------------------------------------------------------------
// utu_pkg
// Shared types and constants for the UTF-8 to UCS transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utu_pkg;

	// input commands (code 3 is ignored)
	typedef enum logic [1:0] {
		CMD_DATA    = 2'd0,
		CMD_END     = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REPL    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	// output forms (bit 1 set selects UTF-32)
	localparam logic [1:0] FORM_UCS2  = 2'd0;
	localparam logic [1:0] FORM_UTF16 = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_OUTPUT_FORM = 2'd0;
	localparam logic [1:0] REG_LSB_FIRST   = 2'd1;
	localparam logic [1:0] REG_WRITE_BOM   = 2'd2;

	// code point constants
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [20:0] REPL_CP     = 21'h00FFFD;
	localparam logic [20:0] BOM_CP      = 21'h00FEFF;
	localparam logic [20:0] SURR_FIRST  = 21'h00D800;
	localparam logic [20:0] SURR_FINAL  = 21'h00DFFF;
	localparam logic [20:0] NONCH_FIRST = 21'h00FDD0;
	localparam logic [20:0] NONCH_FINAL = 21'h00FDEF;
	localparam logic [15:0] BOM_WORD    = 16'hFEFF;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;

	typedef struct packed {
		logic [1:0] output_form;
		logic       lsb_first;
		logic       write_bom;
	} cfg_t;

	// one unit of work for the byte serializer
	typedef struct packed {
		logic        is_err;
		logic [1:0]  status;
		logic        bom;
		logic [20:0] value;
	} job_t;

endpackage

`default_nettype wire

>>> hw/rtl/utu_front.sv
// ----------------------------------------------------------------------------
// utu_front
// Accepts input transactions, gathers UTF-8 sequences, validates code points
// and queues one job per result group.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire utu_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    command,
	input  wire logic [7:0]    in_byte,
	input  wire logic          q_full,
	output logic               push,
	output utu_pkg::job_t      push_job
);

	logic [20:0] pv_q, pv_n;
	logic [1:0]  bp_q, bp_n;
	logic [7:0]  lead_q, lead_n;
	logic        es_q, es_n;
	logic        md_q, md_n;

	logic        accept;
	logic        push_c;
	logic        fin;
	logic [20:0] fin_val;
	logic [20:0] acc;
	logic [7:0]  lo_b, hi_b;
	logic        reject;
	logic        md_eff;
	logic        repl;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign acc      = {pv_q[14:0], in_byte[5:0]};

	// decode and classify
	always_comb begin
		pv_n     = pv_q;
		bp_n     = bp_q;
		lead_n   = lead_q;
		es_n     = es_q;
		md_n     = md_q;
		push_c   = 1'b0;
		push_job = '0;
		fin      = 1'b0;
		fin_val  = '0;
		lo_b     = 8'h80;
		hi_b     = 8'hBF;
		reject   = 1'b0;
		md_eff   = md_q;
		repl     = 1'b0;

		case (command)
			utu_pkg::CMD_END: begin
				if (bp_q != 2'd0) begin
					pv_n            = '0;
					bp_n            = '0;
					lead_n          = '0;
					es_n            = 1'b0;
					push_c          = 1'b1;
					push_job.is_err = 1'b1;
					push_job.status = utu_pkg::ST_TRUNC;
				end
			end
			utu_pkg::CMD_RESTART: begin
				pv_n   = '0;
				bp_n   = '0;
				lead_n = '0;
				es_n   = 1'b0;
				md_n   = !cfg.write_bom;
			end
			utu_pkg::CMD_DATA: begin
				if (bp_q == 2'd0) begin
					if (!in_byte[7]) begin
						fin     = 1'b1;
						fin_val = {13'd0, in_byte};
					end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
						lead_n = in_byte;
						es_n   = 1'b1;
						pv_n   = {16'd0, in_byte[4:0]};
						bp_n   = 2'd1;
					end else if (in_byte[7:4] == 4'hE) begin
						lead_n = in_byte;
						es_n   = 1'b1;
						pv_n   = {17'd0, in_byte[3:0]};
						bp_n   = 2'd2;
					end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
						lead_n = in_byte;
						es_n   = 1'b1;
						pv_n   = {18'd0, in_byte[2:0]};
						bp_n   = 2'd3;
					end else begin
						// illegal lead byte
						push_c          = 1'b1;
						push_job.is_err = 1'b1;
						push_job.status = utu_pkg::ST_ILLEGAL;
					end
				end else begin
					// second byte range depends on the lead byte
					if (es_q) begin
						case (lead_q)
							8'hE0:   lo_b = 8'hA0;
							8'hED:   hi_b = 8'h9F;
							8'hF0:   lo_b = 8'h90;
							8'hF4:   hi_b = 8'h8F;
							default: ;
						endcase
					end
					es_n = 1'b0;
					if (in_byte < lo_b || in_byte > hi_b) begin
						pv_n            = '0;
						bp_n            = '0;
						lead_n          = '0;
						push_c          = 1'b1;
						push_job.is_err = 1'b1;
						push_job.status = utu_pkg::ST_ILLEGAL;
					end else begin
						bp_n = bp_q - 2'd1;
						if (bp_q == 2'd1) begin
							fin     = 1'b1;
							fin_val = acc;
						end else begin
							pv_n = acc;
						end
					end
				end
			end
			default: ;
		endcase

		// completed code point
		if (fin) begin
			pv_n   = '0;
			bp_n   = '0;
			lead_n = '0;
			es_n   = 1'b0;
			reject = (fin_val[15:1] == 15'h7FFF) || (fin_val > utu_pkg::CP_MAX) ||
				(fin_val >= utu_pkg::SURR_FIRST && fin_val <= utu_pkg::SURR_FINAL) ||
				(fin_val >= utu_pkg::NONCH_FIRST && fin_val <= utu_pkg::NONCH_FINAL);
			push_c = 1'b1;
			if (reject) begin
				push_job.is_err = 1'b1;
				push_job.status = utu_pkg::ST_ILLEGAL;
			end else begin
				md_eff = md_q || (fin_val == utu_pkg::BOM_CP);
				repl   = (cfg.output_form == utu_pkg::FORM_UCS2) &&
					(fin_val > utu_pkg::BMP_MAX);
				push_job.status = repl ? utu_pkg::ST_REPL : utu_pkg::ST_OK;
				push_job.value  = repl ? utu_pkg::REPL_CP : fin_val;
				push_job.bom    = cfg.write_bom && !md_eff;
				md_n            = 1'b1;
			end
		end
	end

	assign push = accept && push_c;

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			bp_q   <= '0;
			lead_q <= '0;
			es_q   <= 1'b0;
			md_q   <= 1'b0;   // write_bom resets to one
		end else if (accept) begin
			pv_q   <= pv_n;
			bp_q   <= bp_n;
			lead_q <= lead_n;
			es_q   <= es_n;
			md_q   <= md_n;
		end
	end

`ifndef ASSERT_OFF
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(bp_q == 2'd0) |-> (!es_q && pv_q == '0 && lead_q == '0))
		else $error("sequence state left over with nothing pending");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/utu_fifo.sv
// ----------------------------------------------------------------------------
// utu_fifo
// Short job queue between the decoder and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire utu_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output utu_pkg::job_t      head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utu_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/utu_back.sv
// ----------------------------------------------------------------------------
// utu_back
// Byte serializer: turns the job at the queue head into output bytes,
// byte order mark first, one transaction per cycle while out_ready holds.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire utu_pkg::cfg_t cfg,
	input  wire logic          head_valid,
	input  wire utu_pkg::job_t head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic [1:0]         status,
	output logic               last
);

	logic        wide, pair, le;
	logic [19:0] d;
	logic [15:0] c0, c1, m0, m1;
	logic        nc2;
	logic [1:0]  nm;
	logic [1:0]  nw_m1;
	logic [2:0]  last_idx;
	logic [15:0] w [4];
	logic [15:0] word;
	logic [7:0]  byte_c;
	logic        is_last, fire;

	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  status_q;
	logic        last_q;

	assign wide = cfg.output_form[1];
	assign le   = cfg.lsb_first;
	assign pair = (cfg.output_form == utu_pkg::FORM_UTF16) && (head.value > utu_pkg::BMP_MAX);
	assign d    = 20'(head.value - utu_pkg::SUPP_BASE);

	// code point as 16-bit words in output order
	always_comb begin
		if (wide) begin
			c0  = le ? head.value[15:0] : {11'd0, head.value[20:16]};
			c1  = le ? {11'd0, head.value[20:16]} : head.value[15:0];
			nc2 = 1'b1;
		end else if (pair) begin
			c0  = utu_pkg::HI_SURR | {6'd0, d[19:10]};
			c1  = utu_pkg::LO_SURR | {6'd0, d[9:0]};
			nc2 = 1'b1;
		end else begin
			c0  = head.value[15:0];
			c1  = head.value[15:0];
			nc2 = 1'b0;
		end
	end

	// byte order mark words
	always_comb begin
		if (wide) begin
			m0 = le ? utu_pkg::BOM_WORD : 16'h0000;
			m1 = le ? 16'h0000 : utu_pkg::BOM_WORD;
		end else begin
			m0 = utu_pkg::BOM_WORD;
			m1 = utu_pkg::BOM_WORD;
		end
		nm = head.bom ? (wide ? 2'd2 : 2'd1) : 2'd0;
	end

	// word list and byte selection
	assign w[0]     = (nm == 2'd0) ? c0 : m0;
	assign w[1]     = (nm == 2'd0) ? c1 : ((nm == 2'd1) ? c0 : m1);
	assign w[2]     = (nm == 2'd1) ? c1 : c0;
	assign w[3]     = c1;
	assign nw_m1    = nm + {1'b0, nc2};
	assign last_idx = {nw_m1, 1'b1};
	assign word     = w[idx_q[2:1]];
	assign byte_c   = (idx_q[0] == le) ? word[15:8] : word[7:0];

	assign is_last = head.is_err || (idx_q == last_idx);
	assign fire    = head_valid && (!out_valid_q || out_ready);
	assign pop     = fire && is_last;

	// output register and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= head.is_err ? 8'h00 : byte_c;
			status_q   <= head.status;
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == utu_pkg::ST_ILLEGAL || status_q == utu_pkg::ST_TRUNC))
		|-> (out_byte_q == 8'h00 && last_q))
		else $error("error transaction is not a single zero byte");
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 3'd0) |-> head_valid)
		else $error("job left the queue before its last byte");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/utf8_to_ucs_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs_transcoder_top
// UTF-8 to UCS-2 / UTF-16 / UTF-32 transcoder with configuration registers.
// ----------------------------------------------------------------------------
// The input side takes one transaction per cycle whenever the job queue has
// room; decoding and validation finish in the cycle of acceptance. The output
// side emits one byte per cycle while out_ready holds: a decoded character
// takes 2 to 8 bytes (2 for a BMP character in 16-bit form, 4 for a
// surrogate pair or UTF-32, plus 2 or 4 for a byte order mark), and an error
// takes 1. The single byte serializer sets the sustained rate; QUEUE_DEPTH
// jobs absorb bursts. Every result of an input carries the same status, and
// last marks its final byte. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs_transcoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [1:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] command,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      status,
	output logic            last
);

	utu_pkg::cfg_t cfg_q;
	utu_pkg::job_t push_job, head_job;
	logic          push, q_full, pop, head_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_form <= utu_pkg::FORM_UTF16;
			cfg_q.lsb_first   <= 1'b0;
			cfg_q.write_bom   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				utu_pkg::REG_OUTPUT_FORM: cfg_q.output_form <= cfg_data;
				utu_pkg::REG_LSB_FIRST:   cfg_q.lsb_first   <= cfg_data[0];
				utu_pkg::REG_WRITE_BOM:   cfg_q.write_bom   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	utu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	utu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_job)
	);

	utu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.status     (status),
		.last       (last)
	);

endmodule

`default_nettype wire
